// ----- src/stpf_pkg.sv -----
// Shared constants and the CORDIC arctangent table for the square tag pose fit.
package stpf_pkg;

  localparam int COORD_WIDTH_DEF  = 32;
  localparam int ANGLE_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Angle accumulator: 2^31 is pi, wraps modulo 2^32.
  localparam int ACC_WIDTH      = 32;
  localparam int ATAN_TABLE_LEN = 24;
  localparam int ATAN_IDX_WIDTH = 5;

  localparam logic [ACC_WIDTH-1:0] ANGLE_PLUS_HALF_PI  = 32'h4000_0000;
  localparam logic [ACC_WIDTH-1:0] ANGLE_MINUS_HALF_PI = 32'hC000_0000;

  // Entries in the queue between sum front end and CORDIC back end.
  localparam int QUEUE_DEPTH = 2;

  // Sum widths relative to the corner coordinate width.
  function automatic int sum_width(input int coord_width);
    return coord_width + 3;
  endfunction

  // CORDIC x/y headroom: sums, pre-rotation and the CORDIC gain.
  function automatic int cordic_width(input int coord_width);
    return coord_width + 5;
  endfunction

  // atan(2^-i) in accumulator units.
  function automatic logic [ACC_WIDTH-1:0] atan_unit(input logic [ATAN_IDX_WIDTH-1:0] idx);
    logic [ACC_WIDTH-1:0] val;
    unique case (idx)
      5'd0:    val = 32'h2000_0000;
      5'd1:    val = 32'h12E4_051D;
      5'd2:    val = 32'h09FB_385B;
      5'd3:    val = 32'h0511_11D4;
      5'd4:    val = 32'h028B_0D43;
      5'd5:    val = 32'h0145_D7E1;
      5'd6:    val = 32'h00A2_F61E;
      5'd7:    val = 32'h0051_7C55;
      5'd8:    val = 32'h0028_BE53;
      5'd9:    val = 32'h0014_5F2E;
      5'd10:   val = 32'h000A_2F98;
      5'd11:   val = 32'h0005_17CC;
      5'd12:   val = 32'h0002_8BE6;
      5'd13:   val = 32'h0001_45F3;
      5'd14:   val = 32'h0000_A2F9;
      5'd15:   val = 32'h0000_517C;
      5'd16:   val = 32'h0000_28BE;
      5'd17:   val = 32'h0000_145F;
      5'd18:   val = 32'h0000_0A2F;
      5'd19:   val = 32'h0000_0517;
      5'd20:   val = 32'h0000_028B;
      5'd21:   val = 32'h0000_0145;
      5'd22:   val = 32'h0000_00A2;
      5'd23:   val = 32'h0000_0051;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ----- src/stpf_front.sv -----
// Front end: accepts corner requests and forms the mean and the two weighted sums.
module stpf_front import stpf_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int DATA_WIDTH  = 2 * COORD_WIDTH + 2 * sum_width(COORD_WIDTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] corner0_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner0_y_i,
  input  logic signed [COORD_WIDTH-1:0] corner1_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner1_y_i,
  input  logic signed [COORD_WIDTH-1:0] corner2_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner2_y_i,
  input  logic signed [COORD_WIDTH-1:0] corner3_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner3_y_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output logic [DATA_WIDTH-1:0]         push_data_o
);

  localparam int W1 = COORD_WIDTH + 1;
  localparam int W2 = COORD_WIDTH + 2;
  localparam int SW = sum_width(COORD_WIDTH);

  logic                 s1_valid_q, s1_valid_d;
  logic signed [W1-1:0] x01_q, x23_q, x12_q, x03_q;
  logic signed [W1-1:0] y01_q, y23_q, y03_q, y12_q;
  logic                 accept, push;

  logic signed [W2-1:0] sx, sy, dxa, dya, dxb, dyb;
  logic signed [SW-1:0] sa, sb;

  assign push       = s1_valid_q && push_ready_i;
  assign in_ready_o = !s1_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (push) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Pair sums, one adder level.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x01_q <= W1'(corner0_x_i) + W1'(corner1_x_i);
      x23_q <= W1'(corner2_x_i) + W1'(corner3_x_i);
      x12_q <= W1'(corner1_x_i) + W1'(corner2_x_i);
      x03_q <= W1'(corner0_x_i) + W1'(corner3_x_i);
      y01_q <= W1'(corner0_y_i) + W1'(corner1_y_i);
      y23_q <= W1'(corner2_y_i) + W1'(corner3_y_i);
      y03_q <= W1'(corner0_y_i) + W1'(corner3_y_i);
      y12_q <= W1'(corner1_y_i) + W1'(corner2_y_i);
    end
  end

  // Sa = (x1+x2) - (x0+x3) + (y0+y1) - (y2+y3)
  // Sb = (x0+x1) - (x2+x3) + (y0+y3) - (y1+y2)
  always_comb begin
    sx  = W2'(x01_q) + W2'(x23_q);
    sy  = W2'(y01_q) + W2'(y23_q);
    dxa = W2'(x12_q) - W2'(x03_q);
    dya = W2'(y01_q) - W2'(y23_q);
    dxb = W2'(x01_q) - W2'(x23_q);
    dyb = W2'(y03_q) - W2'(y12_q);
    sa  = SW'(dxa) + SW'(dya);
    sb  = SW'(dxb) + SW'(dyb);
  end

  // Floor mean is the sum with its two low bits dropped.
  assign push_valid_o = s1_valid_q;
  assign push_data_o  = {sx[W2-1:2], sy[W2-1:2], sa, sb};

endmodule

// ----- src/stpf_queue.sv -----
// Small FIFO between the sum front end and the CORDIC back end.
module stpf_queue import stpf_pkg::*; #(
  parameter int DATA_WIDTH = 2 * COORD_WIDTH_DEF + 2 * sum_width(COORD_WIDTH_DEF)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  logic [DATA_WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output logic [DATA_WIDTH-1:0] pop_data_o
);

  localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(QUEUE_DEPTH - 1);
  localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(QUEUE_DEPTH);

  logic [DATA_WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_WIDTH-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_WIDTH-1:0]  count_q;
  logic                  push, pop;

  assign push_ready_o = (count_q != CNT_FULL);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CNT_FULL)
    else $error("queue count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count missed a push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree while empty");

endmodule

// ----- src/stpf_cordic.sv -----
// Back end: iterative vectoring CORDIC for the heading, plus the result register.
module stpf_cordic import stpf_pkg::*; #(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int DATA_WIDTH   = 2 * COORD_WIDTH + 2 * sum_width(COORD_WIDTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [DATA_WIDTH-1:0]         in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] pose_x_o,
  output logic signed [COORD_WIDTH-1:0] pose_y_o,
  output logic signed [ANGLE_WIDTH-1:0] pose_angle_o
);

  localparam int SW    = sum_width(COORD_WIDTH);
  localparam int CW    = cordic_width(COORD_WIDTH);
  localparam int STW   = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int SHIFT = ACC_WIDTH - ANGLE_WIDTH;
  localparam logic [STW-1:0]       STEP_LAST = STW'(CORDIC_STEPS - 1);
  localparam logic [ACC_WIDTH-1:0] RND_HALF  = ACC_WIDTH'(1) << (SHIFT - 1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                       state_q;
  logic [STW-1:0]               step_q;
  logic signed [CW-1:0]         x_q, y_q;
  logic [ACC_WIDTH-1:0]         acc_q;
  logic                         zero_q;
  logic signed [COORD_WIDTH-1:0] mx_q, my_q;
  logic                         out_valid_q;
  logic signed [COORD_WIDTH-1:0] out_x_q, out_y_q;
  logic signed [ANGLE_WIDTH-1:0] out_angle_q;

  logic signed [COORD_WIDTH-1:0] in_mx, in_my;
  logic signed [SW-1:0]         in_sa, in_sb;
  logic signed [CW-1:0]         sa_e, sb_e, x_ld, y_ld;
  logic [ACC_WIDTH-1:0]         acc_ld;
  logic                         zero_ld;

  logic signed [CW-1:0]         dx, dy, x_nx, y_nx;
  logic [ACC_WIDTH-1:0]         acc_nx, rnd_sum;
  logic [ANGLE_WIDTH-1:0]       rounded;
  logic signed [ANGLE_WIDTH-1:0] angle_res;
  logic                         y_pos, last, out_free, finish, load;

  assign {in_mx, in_my, in_sa, in_sb} = in_data_i;

  // Quarter-turn pre-rotation brings the vector into the right half plane.
  always_comb begin
    sa_e    = CW'(in_sa);
    sb_e    = CW'(in_sb);
    zero_ld = (in_sa == '0) && (in_sb == '0);
    x_ld    = sa_e;
    y_ld    = sb_e;
    acc_ld  = '0;
    if (in_sa[SW-1]) begin
      if (!in_sb[SW-1]) begin
        x_ld   = sb_e;
        y_ld   = -sa_e;
        acc_ld = ANGLE_PLUS_HALF_PI;
      end else begin
        x_ld   = -sb_e;
        y_ld   = sa_e;
        acc_ld = ANGLE_MINUS_HALF_PI;
      end
    end
  end

  always_comb begin
    dx    = y_q >>> step_q;
    dy    = x_q >>> step_q;
    y_pos = !y_q[CW-1] && (y_q != '0);
    if (y_pos) begin
      x_nx   = x_q + dx;
      y_nx   = y_q - dy;
      acc_nx = acc_q + atan_unit(ATAN_IDX_WIDTH'(step_q));
    end else begin
      x_nx   = x_q - dx;
      y_nx   = y_q + dy;
      acc_nx = acc_q - atan_unit(ATAN_IDX_WIDTH'(step_q));
    end
    rnd_sum   = acc_nx + RND_HALF;
    rounded   = rnd_sum[ACC_WIDTH-1:SHIFT];
    angle_res = zero_q ? '0 : $signed(-rounded);
  end

  assign last       = (step_q == STEP_LAST);
  assign out_free   = !out_valid_q || out_ready_i;
  assign finish     = (state_q == ST_RUN) && last && out_free;
  assign in_ready_o = (state_q == ST_IDLE) || finish;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (finish) begin
        out_valid_q <= 1'b1;
        out_x_q     <= mx_q;
        out_y_q     <= my_q;
        out_angle_q <= angle_res;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        state_q <= ST_RUN;
        step_q  <= '0;
        x_q     <= x_ld;
        y_q     <= y_ld;
        acc_q   <= acc_ld;
        zero_q  <= zero_ld;
        mx_q    <= in_mx;
        my_q    <= in_my;
      end else if (finish) begin
        state_q <= ST_IDLE;
      end else if ((state_q == ST_RUN) && !last) begin
        step_q <= step_q + 1'b1;
        x_q    <= x_nx;
        y_q    <= y_nx;
        acc_q  <= acc_nx;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pose_x_o     = out_x_q;
  assign pose_y_o     = out_y_q;
  assign pose_angle_o = out_angle_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q <= STEP_LAST))
    else $error("CORDIC step count past last iteration");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (state_q == ST_RUN) && (step_q == '0))
    else $error("CORDIC did not start on load");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_q)
    else $error("finished item not presented");

endmodule

// ----- src/square_tag_pose_fit_unit.sv -----
// Top level of the square tag pose fit: front end, queue and CORDIC back end.
//
// Takes four tag corners (signed Q15.16) per request and returns the corner
// mean and the negated heading as a binary angle (half a turn is
// 2^(ANGLE_WIDTH-1)). The front end adds the corners in one pipeline stage
// and hands the mean and two weighted sums to a two-entry queue. The back end
// runs a vectoring CORDIC, one iteration per cycle; that loop sets the rate
// of a sustained stream. The back end loads the next request in the cycle
// in which it hands the last result to the output register. A request is
// taken while an earlier result still waits on the output register.
module square_tag_pose_fit_unit import stpf_pkg::*; #(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] corner0_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner0_y_i,
  input  logic signed [COORD_WIDTH-1:0] corner1_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner1_y_i,
  input  logic signed [COORD_WIDTH-1:0] corner2_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner2_y_i,
  input  logic signed [COORD_WIDTH-1:0] corner3_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner3_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] pose_x_o,
  output logic signed [COORD_WIDTH-1:0] pose_y_o,
  output logic signed [ANGLE_WIDTH-1:0] pose_angle_o
);

  localparam int DATA_WIDTH = 2 * COORD_WIDTH + 2 * sum_width(COORD_WIDTH);

  logic                  push_valid, push_ready;
  logic [DATA_WIDTH-1:0] push_data;
  logic                  pop_valid, pop_ready;
  logic [DATA_WIDTH-1:0] pop_data;

  stpf_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .corner0_x_i  (corner0_x_i),
    .corner0_y_i  (corner0_y_i),
    .corner1_x_i  (corner1_x_i),
    .corner1_y_i  (corner1_y_i),
    .corner2_x_i  (corner2_x_i),
    .corner2_y_i  (corner2_y_i),
    .corner3_x_i  (corner3_x_i),
    .corner3_y_i  (corner3_y_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  stpf_queue #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  stpf_cordic #(
    .COORD_WIDTH  (COORD_WIDTH),
    .ANGLE_WIDTH  (ANGLE_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_cordic (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (pop_valid),
    .in_ready_o   (pop_ready),
    .in_data_i    (pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pose_x_o     (pose_x_o),
    .pose_y_o     (pose_y_o),
    .pose_angle_o (pose_angle_o)
  );

endmodule
